### src/llwd_pkg.sv
// ----------------------------------------------------------------------------
// llwd_pkg
// Shared constants and types for the least-loaded worker dispatcher.
// ----------------------------------------------------------------------------
package llwd_pkg;

   localparam int SLOT_COUNT     = 16;
   localparam int JOB_COUNT_BITS = 8;
   localparam int SLOT_BITS      = $clog2(SLOT_COUNT);
   localparam int ACT_BITS       = $clog2(SLOT_COUNT + 1);

   localparam logic [JOB_COUNT_BITS-1:0] JOB_MAX = {JOB_COUNT_BITS{1'b1}};

   // request actions
   localparam logic [1:0] ACT_DISPATCH = 2'd0;
   localparam logic [1:0] ACT_COMPLETE = 2'd1;
   localparam logic [1:0] ACT_RELEASE  = 2'd2;
   localparam logic [1:0] ACT_REGISTER = 2'd3;

   // response status
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NO_WORKER = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_EMPTY     = 2'd3;

   // job count memory access
   typedef struct packed {
      logic                      rd_en;
      logic [SLOT_BITS-1:0]      rd_addr;
      logic                      wr_en;
      logic [SLOT_BITS-1:0]      wr_addr;
      logic [JOB_COUNT_BITS-1:0] wr_data;
   } ram_cmd_type;

   // occupancy update
   typedef struct packed {
      logic                 set;
      logic                 clr;
      logic [SLOT_BITS-1:0] idx;
   } occ_cmd_type;

   // occupancy status
   typedef struct packed {
      logic [SLOT_COUNT-1:0] occ;
      logic                  free_vld;
      logic [SLOT_BITS-1:0]  free_idx;
      logic [ACT_BITS-1:0]   active;
   } occ_stat_type;

endpackage

### src/least_loaded_worker_dispatcher_core.sv
// ----------------------------------------------------------------------------
// least_loaded_worker_dispatcher_core
// Worker slot table with least-loaded job dispatch.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one response
// follows, shown for a single cycle with rsp_strobe high. The receiver cannot
// stall, so it must capture the response in that cycle. One request is worked
// at a time. Dispatch scans the job count memory one slot per cycle (one read
// port, registered read): the slot reads, then a compare of the last read, a
// bump of the winner's count and the strobe. busy drops the cycle after.
// Complete takes a read-modify-write before its strobe; register, release and
// requests on an empty slot strobe in the cycle right after the accept.
// Occupancy lives in flip-flops cleared by reset; job counts live in a memory
// that is written to zero whenever a slot is registered or released, so no
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module least_loaded_worker_dispatcher_core
   import llwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_slot_id,
   // response
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_chosen_slot,
   output logic [7:0]  rsp_job_count,
   output logic [4:0]  rsp_active_count
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,  // stream job counts through the compare
      ST_PICK = 5'b00100,  // bump the winner's count
      ST_CMPL = 5'b01000,  // decrement after read
      ST_RESP = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;

   // scan bookkeeping
   logic [SLOT_BITS:0]        scan_idx_ff, scan_idx_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [SLOT_BITS-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                      found_ff, found_in;
   logic [SLOT_BITS-1:0]      best_idx_ff, best_idx_in;
   logic [JOB_COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;

   // latched request / response payload
   logic [SLOT_BITS-1:0]      sid_ff, sid_in;
   logic [1:0]                status_ff, status_in;
   logic [SLOT_BITS-1:0]      chosen_ff, chosen_in;
   logic [JOB_COUNT_BITS-1:0] jobs_ff, jobs_in;

   ram_cmd_type               ram_cmd;
   logic [JOB_COUNT_BITS-1:0] ram_rd_data;
   occ_cmd_type               occ_cmd;
   occ_stat_type              occ_stat;

   logic                      accept;
   logic                      sid_in_range;
   logic                      sid_occ;
   logic                      candidate;

   llwd_job_ram u_job_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rd_data)
   );

   llwd_slot_table u_slot_table (
      .clock (clock),
      .reset (reset),
      .cmd   (occ_cmd),
      .stat  (occ_stat)
   );

   assign accept       = start && (state_ff == ST_IDLE);
   assign sid_in_range = ({1'b0, req_slot_id} < (SLOT_COUNT));
   assign sid_occ      = sid_in_range && occ_stat.occ[req_slot_id[SLOT_BITS-1:0]];

   // slot under compare: occupied and not saturated
   assign candidate = cmp_vld_ff && occ_stat.occ[cmp_idx_ff] && (ram_rd_data != JOB_MAX);

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_cnt_in = best_cnt_ff;
      sid_in      = sid_ff;
      status_in   = status_ff;
      chosen_in   = chosen_ff;
      jobs_in     = jobs_ff;
      ram_cmd     = '0;
      occ_cmd     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sid_in    = req_slot_id[SLOT_BITS-1:0];
               status_in = STAT_OK;
               chosen_in = '0;
               jobs_in   = '0;
               case (req_action)
                  ACT_DISPATCH: begin
                     scan_idx_in = '0;
                     found_in    = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  ACT_REGISTER: begin
                     if (occ_stat.free_vld) begin
                        chosen_in       = occ_stat.free_idx;
                        occ_cmd.set     = 1'b1;
                        occ_cmd.idx     = occ_stat.free_idx;
                        ram_cmd.wr_en   = 1'b1;
                        ram_cmd.wr_addr = occ_stat.free_idx;
                        ram_cmd.wr_data = '0;
                     end else begin
                        status_in = STAT_FULL;
                     end
                     state_in = ST_RESP;
                  end
                  default: begin
                     // complete or release
                     chosen_in = req_slot_id[SLOT_BITS-1:0];
                     if (!sid_occ) begin
                        status_in = STAT_EMPTY;
                        state_in  = ST_RESP;
                     end else if (req_action == ACT_COMPLETE) begin
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = req_slot_id[SLOT_BITS-1:0];
                        state_in        = ST_CMPL;
                     end else begin
                        occ_cmd.clr     = 1'b1;
                        occ_cmd.idx     = req_slot_id[SLOT_BITS-1:0];
                        ram_cmd.wr_en   = 1'b1;
                        ram_cmd.wr_addr = req_slot_id[SLOT_BITS-1:0];
                        ram_cmd.wr_data = '0;
                        state_in        = ST_RESP;
                     end
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // issue read of the next slot while comparing the previous one
            if (scan_idx_ff < (SLOT_BITS+1)'(SLOT_COUNT)) begin
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = scan_idx_ff[SLOT_BITS-1:0];
               cmp_vld_in      = 1'b1;
               cmp_idx_in      = scan_idx_ff[SLOT_BITS-1:0];
               scan_idx_in     = scan_idx_ff + (SLOT_BITS+1)'(1);
            end else begin
               state_in = ST_PICK;
            end
            if (candidate && (!found_ff || (ram_rd_data < best_cnt_ff))) begin
               found_in    = 1'b1;
               best_idx_in = cmp_idx_ff;
               best_cnt_in = ram_rd_data;
            end
         end

         ST_PICK: begin
            if (found_ff) begin
               ram_cmd.wr_en   = 1'b1;
               ram_cmd.wr_addr = best_idx_ff;
               ram_cmd.wr_data = best_cnt_ff + JOB_COUNT_BITS'(1);
               chosen_in       = best_idx_ff;
               jobs_in         = best_cnt_ff + JOB_COUNT_BITS'(1);
            end else begin
               status_in = STAT_NO_WORKER;
            end
            state_in = ST_RESP;
         end

         ST_CMPL: begin
            // count floors at zero
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = sid_ff;
            if (ram_rd_data != '0) begin
               ram_cmd.wr_data = ram_rd_data - JOB_COUNT_BITS'(1);
               jobs_in         = ram_rd_data - JOB_COUNT_BITS'(1);
            end else begin
               ram_cmd.wr_data = '0;
               jobs_in         = '0;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_cnt_ff <= best_cnt_in;
      sid_ff      <= sid_in;
      status_ff   <= status_in;
      chosen_ff   <= chosen_in;
      jobs_ff     <= jobs_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = (state_ff == ST_RESP);
   assign rsp_status       = status_ff;
   assign rsp_chosen_slot  = chosen_ff;
   assign rsp_job_count    = jobs_ff;
   // occupancy updates land on the edge into ST_RESP
   assign rsp_active_count = occ_stat.active;

endmodule

### src/llwd_job_ram.sv
// ----------------------------------------------------------------------------
// llwd_job_ram
// Outstanding job count per slot: one write port, one registered read port.
// ----------------------------------------------------------------------------
module llwd_job_ram
   import llwd_pkg::*;
(
   input  logic                      clock,
   input  ram_cmd_type               cmd,
   output logic [JOB_COUNT_BITS-1:0] rd_data
);

   logic [JOB_COUNT_BITS-1:0] mem [SLOT_COUNT];
   logic [JOB_COUNT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/llwd_slot_table.sv
// ----------------------------------------------------------------------------
// llwd_slot_table
// Slot occupancy bits, occupied-slot count and lowest-free-slot search.
// ----------------------------------------------------------------------------
module llwd_slot_table
   import llwd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  occ_cmd_type  cmd,
   output occ_stat_type stat
);

   logic [SLOT_COUNT-1:0] occ_ff;
   logic [SLOT_COUNT-1:0] occ_in;
   logic [ACT_BITS-1:0]   active_ff;
   logic [ACT_BITS-1:0]   active_in;
   logic                  free_vld;
   logic [SLOT_BITS-1:0]  free_idx;

   always_comb begin
      occ_in    = occ_ff;
      active_in = active_ff;
      // callers only set a free slot and clear an occupied one
      if (cmd.set) begin
         occ_in[cmd.idx] = 1'b1;
         active_in       = active_ff + ACT_BITS'(1);
      end else if (cmd.clr) begin
         occ_in[cmd.idx] = 1'b0;
         active_in       = active_ff - ACT_BITS'(1);
      end
   end

   // lowest empty slot
   always_comb begin
      free_vld = 1'b0;
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!occ_ff[i]) begin
            free_vld = 1'b1;
            free_idx = SLOT_BITS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         active_ff <= '0;
      end else begin
         occ_ff    <= occ_in;
         active_ff <= active_in;
      end
   end

   assign stat.occ      = occ_ff;
   assign stat.free_vld = free_vld;
   assign stat.free_idx = free_idx;
   assign stat.active   = active_ff;

endmodule
